@@ rtl/core/pva_pkg.sv @@
// shared types, constants and arctangent table for the polar vector adder
package pva_pkg;

  localparam int CompW       = 34;
  localparam int AngW        = 26;
  localparam int AtanEntries = 24;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [AngW-1:0]  ang_t;

  localparam logic [23:0] InvGain      = 24'd10188014;
  localparam logic signed [17:0] TurnUnits    = 18'sd46080;
  localparam logic signed [17:0] HalfTurn     = 18'sd23040;
  localparam logic signed [17:0] QuarterTurn  = 18'sd11520;
  localparam ang_t HalfTurnFine = 26'sd11796480;
  localparam logic [16:0] MagMax = 17'd131071;

  // atan(2^-i) in units of 2^-16 degree
  function automatic ang_t atan_fine(input logic [4:0] idx);
    ang_t v;
    unique case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/pva_cell.sv @@
// one cordic micro-rotation cell, registered, for rotation or vectoring chains
module pva_cell #(
  parameter int IDX = 0,
  parameter bit VEC = 1'b0
) (
  input  logic           clk,
  input  pva_pkg::comp_t x_i,
  input  pva_pkg::comp_t y_i,
  input  pva_pkg::ang_t  z_i,
  output pva_pkg::comp_t x_o,
  output pva_pkg::comp_t y_o,
  output pva_pkg::ang_t  z_o
);

  localparam logic [4:0] Sel = IDX[4:0];

  pva_pkg::comp_t x_r, y_r, dx, dy;
  pva_pkg::ang_t  z_r, at;
  logic           pos;

  assign dx  = y_i >>> IDX;
  assign dy  = x_i >>> IDX;
  assign at  = pva_pkg::atan_fine(Sel);
  // rotation steers on angle sign, vectoring on y sign
  assign pos = VEC ? y_i[pva_pkg::CompW-1] : ~z_i[pva_pkg::AngW-1];

  always_ff @(posedge clk) begin
    if (pos) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - at;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + at;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

@@ rtl/core/polar_vector_adder_core.sv @@
// top level of the pipelined polar vector adder
// usage:
//   an item (two vectors as length and angle) is taken at each clock edge with
//   start high and busy low; busy is high only while reset is held, so a new
//   item may enter every cycle
//   the result (magnitude, direction) is on the out_ ports for one cycle with
//   out_valid high, once the item has passed all the register rows listed
//   below (N is CORDIC_STAGES, at most 24)
//   throughput is one item per cycle: every stage is a register row and
//   each cordic micro-rotation is its own cell in a chain
//   pipeline: angle reduce, gain multiply, N rotation cells per vector,
//   component sum, quadrant fix, N vectoring cells, split gain multiply,
//   round and saturate into the output register (2*N+6 register rows)
//   the receiver cannot stall; results must be taken when out_valid is high
//   synchronous reset clears all valid bits; items in flight are dropped,
//   datapath registers are left as they are
//   a zero resultant gives magnitude 0 and direction 0
module polar_vector_adder_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_first_length,
  input  logic signed [16:0] in_first_angle,
  input  logic [15:0]        in_second_length,
  input  logic signed [16:0] in_second_angle,
  output logic               out_valid,
  output logic [16:0]        out_magnitude,
  output logic signed [15:0] out_direction
);

  localparam int N = (CORDIC_STAGES > pva_pkg::AtanEntries) ?
                     pva_pkg::AtanEntries : CORDIC_STAGES;

  // reduce to [-180,180) then fold into +-90, flag for negated start vector
  function automatic logic [16:0] fold_angle(input logic signed [16:0] a);
    logic signed [17:0] r;
    logic               ng;
    r  = 18'(a);
    ng = 1'b0;
    if (r >= pva_pkg::HalfTurn) r = r - pva_pkg::TurnUnits;
    else if (r < -pva_pkg::HalfTurn) r = r + pva_pkg::TurnUnits;
    if (r > pva_pkg::QuarterTurn) begin
      r  = r - pva_pkg::HalfTurn;
      ng = 1'b1;
    end else if (r < -pva_pkg::QuarterTurn) begin
      r  = r + pva_pkg::HalfTurn;
      ng = 1'b1;
    end
    return {ng, r[15:0]};
  endfunction

  // no item is taken while reset is held
  assign busy = ~rst_n;

  // valid tracking
  logic         v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, out_valid_r;
  logic [N-1:0] v_rot_r, v_vec_r;
  logic         zf_d_r, zf_e_r;
  logic [N-1:0] zf_vec_r;

  // stage a: folded angles
  logic [15:0]        len_a_r [2];
  logic signed [15:0] r_a_r   [2];
  logic               neg_a_r [2];
  logic [16:0]        fold0, fold1;

  assign fold0 = fold_angle(in_first_angle);
  assign fold1 = fold_angle(in_second_angle);

  always_ff @(posedge clk) begin
    len_a_r[0] <= in_first_length;
    len_a_r[1] <= in_second_length;
    r_a_r[0]   <= signed'(fold0[15:0]);
    r_a_r[1]   <= signed'(fold1[15:0]);
    neg_a_r[0] <= fold0[16];
    neg_a_r[1] <= fold1[16];
  end

  // stage b: start vector with gain correction, chains of rotation cells
  pva_pkg::comp_t rx [2][N+1];
  pva_pkg::comp_t ry [2][N+1];
  pva_pkg::ang_t  rz [2][N+1];

  for (genvar v = 0; v < 2; v++) begin : g_vec
    logic [39:0]    prod;
    logic [27:0]    m;
    pva_pkg::comp_t x_b_r;
    pva_pkg::ang_t  z_b_r;

    assign prod = 40'(len_a_r[v]) * 40'(pva_pkg::InvGain) + 40'd2048;
    assign m    = prod[39:12];

    always_ff @(posedge clk) begin
      x_b_r <= neg_a_r[v] ? -pva_pkg::comp_t'(m) : pva_pkg::comp_t'(m);
      // sign-extended angle scaled to 2^-16 degree
      z_b_r <= {r_a_r[v][15], r_a_r[v], 9'd0};
    end

    assign rx[v][0] = x_b_r;
    assign ry[v][0] = '0;
    assign rz[v][0] = z_b_r;

    for (genvar i = 0; i < N; i++) begin : g_cell
      pva_cell #(.IDX(i), .VEC(1'b0)) u_cell (
        .clk (clk),
        .x_i (rx[v][i]), .y_i (ry[v][i]), .z_i (rz[v][i]),
        .x_o (rx[v][i+1]), .y_o (ry[v][i+1]), .z_o (rz[v][i+1])
      );
    end
  end

  // stage c: component sum
  pva_pkg::comp_t sx_c_r, sy_c_r;
  always_ff @(posedge clk) begin
    sx_c_r <= rx[0][N] + rx[1][N];
    sy_c_r <= ry[0][N] + ry[1][N];
  end

  // stage d: left half plane goes to the right half, angle starts at +-180
  pva_pkg::comp_t vx [N+1];
  pva_pkg::comp_t vy [N+1];
  pva_pkg::ang_t  vz [N+1];
  pva_pkg::comp_t x_d_r, y_d_r;
  pva_pkg::ang_t  z_d_r;

  always_ff @(posedge clk) begin
    if (sx_c_r[pva_pkg::CompW-1]) begin
      x_d_r <= -sx_c_r;
      y_d_r <= -sy_c_r;
      z_d_r <= sy_c_r[pva_pkg::CompW-1] ? -pva_pkg::HalfTurnFine : pva_pkg::HalfTurnFine;
    end else begin
      x_d_r <= sx_c_r;
      y_d_r <= sy_c_r;
      z_d_r <= '0;
    end
  end

  assign vx[0] = x_d_r;
  assign vy[0] = y_d_r;
  assign vz[0] = z_d_r;

  for (genvar i = 0; i < N; i++) begin : g_vcell
    pva_cell #(.IDX(i), .VEC(1'b1)) u_cell (
      .clk (clk),
      .x_i (vx[i]), .y_i (vy[i]), .z_i (vz[i]),
      .x_o (vx[i+1]), .y_o (vy[i+1]), .z_o (vz[i+1])
    );
  end

  // stage e: clamp x, split gain multiply, round and clamp direction
  logic [17:0]        xh;
  logic [15:0]        xl;
  logic [41:0]        p_hi_e_r;
  logic [39:0]        p_lo_e_r;
  logic signed [16:0] d_raw;
  logic signed [15:0] d_e_r, d_clamp;
  pva_pkg::ang_t      z_rnd;

  assign xh    = vx[N][pva_pkg::CompW-1] ? 18'd0 : vx[N][33:16];
  assign xl    = vx[N][pva_pkg::CompW-1] ? 16'd0 : vx[N][15:0];
  assign z_rnd = vz[N] + pva_pkg::ang_t'(256);
  assign d_raw = z_rnd[25:9];

  always_comb begin
    priority if (d_raw > 17'(pva_pkg::HalfTurn)) d_clamp = 16'(pva_pkg::HalfTurn);
    else if (d_raw < -17'(pva_pkg::HalfTurn)) d_clamp = -16'(pva_pkg::HalfTurn);
    else d_clamp = d_raw[15:0];
  end

  always_ff @(posedge clk) begin
    p_hi_e_r <= 42'(xh) * 42'(pva_pkg::InvGain);
    p_lo_e_r <= 40'(xl) * 40'(pva_pkg::InvGain);
    d_e_r    <= d_clamp;
  end

  // stage f: recombine partial products, round, saturate
  logic [57:0] psum;
  logic [21:0] mag_full;
  logic [16:0] mag_sat;

  assign psum     = {p_hi_e_r, 16'd0} + 58'(p_lo_e_r) + (58'd1 << 35);
  assign mag_full = psum[57:36];
  assign mag_sat  = (mag_full > 22'(pva_pkg::MagMax)) ? pva_pkg::MagMax : mag_full[16:0];

  logic [16:0]        mag_r;
  logic signed [15:0] dir_r;

  always_ff @(posedge clk) begin
    mag_r <= zf_e_r ? 17'd0 : mag_sat;
    dir_r <= zf_e_r ? 16'sd0 : d_e_r;
  end

  // zero resultant flag rides along the vectoring chain
  logic [N-1:0] zf_vec_nxt;
  if (N > 1) begin : g_zf_shift
    assign zf_vec_nxt = {zf_vec_r[N-2:0], zf_d_r};
  end else begin : g_zf_one
    assign zf_vec_nxt = zf_d_r;
  end

  always_ff @(posedge clk) begin
    zf_d_r   <= (sx_c_r == '0) && (sy_c_r == '0);
    zf_vec_r <= zf_vec_nxt;
    zf_e_r   <= zf_vec_r[N-1];
  end

  // valid shift line
  logic [N-1:0] v_rot_nxt, v_vec_nxt;
  if (N > 1) begin : g_v_shift
    assign v_rot_nxt = {v_rot_r[N-2:0], v_b_r};
    assign v_vec_nxt = {v_vec_r[N-2:0], v_d_r};
  end else begin : g_v_one
    assign v_rot_nxt = v_b_r;
    assign v_vec_nxt = v_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_rot_r     <= '0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      v_vec_r     <= '0;
      v_e_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_a_r       <= start;
      v_b_r       <= v_a_r;
      v_rot_r     <= v_rot_nxt;
      v_c_r       <= v_rot_r[N-1];
      v_d_r       <= v_c_r;
      v_vec_r     <= v_vec_nxt;
      v_e_r       <= v_vec_r[N-1];
      out_valid_r <= v_e_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = mag_r;
  assign out_direction = dir_r;

endmodule

@@ rtl/core/pva_checker.sv @@
// port-level checker for the polar vector adder, bound to the top level
module pva_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [15:0]        in_first_length,
  input logic [15:0]        in_second_length,
  input logic               out_valid,
  input logic [16:0]        out_magnitude,
  input logic signed [15:0] out_direction
);

  localparam int N   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int Lat = 2 * N + 6;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Lat))
    else $error("result without an item");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction <= 16'sd23040) && (out_direction >= -16'sd23040))
    else $error("direction out of range");

  a_zero_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_first_length == 16'd0 && in_second_length == 16'd0, Lat)
      |-> (out_magnitude == 17'd0) && (out_direction == 16'sd0))
    else $error("zero vectors gave nonzero result");

endmodule

bind polar_vector_adder_core pva_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_pva_checker (.*);

@@ test/polar_vector_adder_core_checker.sv @@
// result predictor and scoreboard for the polar vector adder
module polar_vector_adder_core_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [15:0]        in_first_length,
  input  logic signed [16:0] in_first_angle,
  input  logic [15:0]        in_second_length,
  input  logic signed [16:0] in_second_angle,
  input  logic               out_valid,
  input  logic [16:0]        out_magnitude,
  input  logic signed [15:0] out_direction,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0]        mag;
    logic signed [15:0] dir;
  } resultant_t;

  resultant_t expected_q[$];
  int         err_count = 0;

  localparam longint InvGainL = 10188014;

  function automatic longint atan_entry(input int i);
    longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  function automatic int n_stages();
    return (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  endfunction

  // rotation mode: polar vector into x/y components
  function automatic void rotate_vector(input longint len, input longint ang,
                                        output longint xo, output longint yo);
    longint r, x, y, z, dx, dy;
    r = ang % 46080;
    if (r < 0) r += 46080;
    if (r >= 23040) r -= 46080;
    x = (len * InvGainL + 2048) >>> 12;
    y = 0;
    if (r > 11520) begin
      r -= 23040;
      x = -x;
    end else if (r < -11520) begin
      r += 23040;
      x = -x;
    end
    z = r * 512;
    for (int i = 0; i < n_stages(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic resultant_t add_vectors(input logic [15:0] l1, input logic signed [16:0] a1,
                                             input logic [15:0] l2, input logic signed [16:0] a2);
    longint x1, y1, x2, y2, x, y, z, dx, dy, m, d;
    resultant_t res;
    rotate_vector(longint'(l1), longint'(a1), x1, y1);
    rotate_vector(longint'(l2), longint'(a2), x2, y2);
    x = x1 + x2;
    y = y1 + y2;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane starts from +-180 degrees
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n_stages(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    if (x < 0) x = 0;
    m = (x * InvGainL + (longint'(1) << 35)) >>> 36;
    if (m > 131071) m = 131071;
    d = (z + 256) >>> 9;
    if (d > 23040) d = 23040;
    if (d < -23040) d = -23040;
    res.mag = m[16:0];
    res.dir = d[15:0];
    return res;
  endfunction

  assign pending    = expected_q.size();
  assign fail_count = err_count;

  always @(posedge clk) begin
    resultant_t want;
    if (rst_n && start && !busy)
      expected_q.push_back(add_vectors(in_first_length, in_first_angle,
                                       in_second_length, in_second_angle));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected item: mag %0d dir %0d", out_magnitude, out_direction);
      end else begin
        want = expected_q.pop_front();
        if (want.mag !== out_magnitude || want.dir !== out_direction) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: mag exp %0d got %0d, dir exp %0d got %0d",
                     want.mag, out_magnitude, want.dir, out_direction);
        end
      end
    end
  end

endmodule

@@ test/polar_vector_adder_core_test.sv @@
// stimulus and verdict for the polar vector adder testbench
module polar_vector_adder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages = 16;
  localparam int Latency = 2 * Stages + 6;
  localparam int RandomItems = 1900;
  localparam longint CycleLimit = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [15:0]        in_first_length = '0;
  logic signed [16:0] in_first_angle = '0;
  logic [15:0]        in_second_length = '0;
  logic signed [16:0] in_second_angle = '0;
  logic               out_valid;
  logic [16:0]        out_magnitude;
  logic signed [15:0] out_direction;
  int                 fail_count;
  int                 pending;
  longint             cycle_count = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polar_vector_adder_core #(.CORDIC_STAGES(Stages)) u_dut (.*);

  polar_vector_adder_core_checker #(.CORDIC_STAGES(Stages)) u_checker (.*);

  // watchdog against a stuck pipeline
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one item at the falling edge and hold it until it is taken
  task automatic send_pair(input logic [15:0] l1, input logic signed [16:0] a1,
                           input logic [15:0] l2, input logic signed [16:0] a2);
    start            <= 1'b1;
    in_first_length  <= l1;
    in_first_angle   <= a1;
    in_second_length <= l2;
    in_second_angle  <= a2;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // lowers start for the number of cycles given in its argument
  task automatic pause_input(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // any angle in the full field range, biased to the legal span
  function automatic logic signed [16:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 17'($urandom);
    if (sel == 1) begin
      // quadrant boundaries, the half turn, zero and just under a full turn
      case ($urandom_range(0, 5))
        0: return 17'sd11520;
        1: return -17'sd11520;
        2: return 17'sd23040;
        3: return -17'sd23040;
        4: return 17'sd0;
        default: return 17'sd46079;
      endcase
    end
    return 17'($signed($urandom_range(0, 92159)) - 46080);
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'($urandom_range(0, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  logic [15:0] len_a;
  logic signed [16:0] ang_a;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, maximum lengths, boundary angles and wraps
    send_pair(16'd0, 17'sd0, 16'd0, 17'sd0);
    send_pair(16'hffff, 17'sd0, 16'hffff, 17'sd0);
    send_pair(16'hffff, 17'sd11520, 16'hffff, 17'sd11520);
    send_pair(16'hffff, -17'sd46080, 16'd0, 17'sd46079);
    send_pair(16'd100, 17'sd0, 16'd100, 17'sd23040);      // exact cancel
    send_pair(16'd100, 17'sd11520, 16'd100, -17'sd11520); // cancel on y axis
    send_pair(16'd1, 17'sd23040, 16'd0, 17'sd0);          // left half, y zero
    send_pair(16'd50, 17'sd23039, 16'd0, 17'sd0);
    send_pair(16'd50, -17'sd23039, 16'd0, 17'sd0);
    send_pair(16'd50, -17'sd23040, 16'd50, -17'sd23040);
    send_pair(16'd1, 17'sd11521, 16'd1, -17'sd11521);
    send_pair(16'd1, 17'sd46079, 16'hffff, -17'sd46080);
    send_pair(16'hffff, 17'sd65535, 16'hffff, 17'sh10000); // field extremes
    send_pair(16'h8000, 17'sd34560, 16'h7fff, -17'sd34560);
    send_pair(16'd16, 17'sd5760, 16'd16, 17'sd17280);
    send_pair(16'hffff, 17'sd23040, 16'hffff, 17'sd23040);
    send_pair(16'd0, 17'sd100, 16'd1, 17'sd0);
    send_pair(16'h5555, 17'sh0aaaa, 16'haaaa, 17'sh15555);

    // random part; the final stretch runs at full rate
    for (int i = 0; i < RandomItems; i++) begin
      if (i < RandomItems - 300 && $urandom_range(0, 5) == 0)
        pause_input($urandom_range(1, 13));
      len_a = pick_length();
      ang_a = pick_angle();
      if ($urandom_range(0, 9) == 0)
        send_pair(len_a, ang_a, len_a, ang_a + 17'sd23040); // near cancel
      else
        send_pair(len_a, ang_a, pick_length(), pick_angle());
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pva_pkg.sv
rtl/core/pva_cell.sv
rtl/core/polar_vector_adder_core.sv
rtl/core/pva_checker.sv
test/polar_vector_adder_core_checker.sv
test/polar_vector_adder_core_test.sv
